FILE: src/spq_pkg.sv
package spq_pkg;

	// Queue sizing
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Operation codes
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_DEQUEUE = 1'b1;

	// Result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	// Request word
	typedef struct packed {
		logic               cmd;
		logic signed [31:0] item_value;
		logic signed [15:0] item_priority;
	} req_word_t;

	// Response word
	typedef struct packed {
		logic signed [31:0] out_value;
		logic [1:0]         status;
		logic               queue_empty;
		logic [4:0]         entry_count;
	} rsp_word_t;

	// One stored entry
	typedef struct packed {
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Logical slot to physical RAM address, ring starting at head
	function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
			input logic [IDX_W-1:0] slot);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + {1'b0, slot};
		if (sum >= (IDX_W + 1)'(CAPACITY)) begin
			sum = sum - (IDX_W + 1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

	// Count to the 5-bit result field (wraps above 31)
	function automatic logic [4:0] count_field(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+4:0] wide;
		wide = {5'b0, cnt};
		return wide[4:0];
	endfunction

endpackage

FILE: src/sorted_priority_queue.sv
// Bounded priority queue of CAPACITY entries (value, signed priority), served highest
// priority first; an entry goes ahead of held entries of equal priority. Entries live in
// one RAM used as a ring: a dequeue reads the head slot and advances the head, while an
// enqueue walks from the tail towards the head, one entry per cycle, reading the next
// slot down while writing the current one up by one, until it finds an entry of
// strictly higher priority or reaches the head. Enqueue on a full queue and dequeue
// on an empty one answer straight from the idle state. One word is processed at a time;
// a new word is taken once the queue is idle and the response register is free or being
// emptied.
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_DEQ  = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [IDX_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] slot_q, slot_d;
	entry_t           new_q;
	logic             rsp_valid_q;
	rsp_word_t        rsp_q;

	logic             accept;
	logic             fin;
	rsp_word_t        fin_word;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_rdata;

	spq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;

	// Sequencer: walk, shift and place for enqueue; read and advance the head for dequeue
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		cnt_d     = cnt_q;
		slot_d    = slot_q;
		ram_we    = 1'b0;
		ram_waddr = phys_idx(head_q, slot_q);
		ram_wdata = ram_rdata;
		ram_raddr = head_q;
		fin       = 1'b0;
		fin_word  = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_ENQUEUE) begin
						if (cnt_q >= CNT_W'(CAPACITY)) begin
							fin             = 1'b1;
							fin_word.status = STATUS_FULL;
						end else if (cnt_q == '0) begin
							ram_we    = 1'b1;
							ram_waddr = head_q;
							ram_wdata = '{value: req.item_value, prio: req.item_priority};
							cnt_d     = cnt_q + CNT_W'(1);
							fin       = 1'b1;
						end else begin
							ram_raddr = phys_idx(head_q, IDX_W'(cnt_q - CNT_W'(1)));
							slot_d    = IDX_W'(cnt_q);
							state_d   = ST_WALK;
						end
					end else begin
						if (cnt_q == '0) begin
							fin                = 1'b1;
							fin_word.status    = STATUS_UNDERFLOW;
							fin_word.out_value = '1;
						end else begin
							state_d = ST_DEQ;
						end
					end
				end
			end
			ST_WALK: begin
				ram_we = 1'b1;
				if (ram_rdata.prio > new_q.prio) begin
					ram_wdata = new_q;
					cnt_d     = cnt_q + CNT_W'(1);
					fin       = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					// shift entry up one slot, fetch the next one down
					slot_d    = slot_q - IDX_W'(1);
					ram_raddr = phys_idx(head_q, slot_q - IDX_W'(2));
					if (slot_q == IDX_W'(1)) begin
						state_d = ST_LAST;
					end
				end
			end
			ST_LAST: begin
				ram_we    = 1'b1;
				ram_wdata = new_q;
				cnt_d     = cnt_q + CNT_W'(1);
				fin       = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_DEQ: begin
				fin                = 1'b1;
				fin_word.out_value = ram_rdata.value;
				cnt_d              = cnt_q - CNT_W'(1);
				head_d             = (head_q == IDX_W'(CAPACITY - 1)) ? '0
					: head_q + IDX_W'(1);
				state_d            = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		fin_word.entry_count = count_field(cnt_d);
		fin_word.queue_empty = (cnt_d == '0);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			slot_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
			slot_q  <= slot_d;
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			new_q <= '{value: req.item_value, prio: req.item_priority};
		end
		if (fin) begin
			rsp_q <= fin_word;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: src/spq_ram.sv
// Simple dual-port RAM, one write port, one registered read port
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/spq_checker.sv
// Port-level checks on the response word
module spq_port_checks
	import spq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_word_t rsp
);

	// stalled word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// empty flag agrees with count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (CAPACITY < 32) |-> rsp.queue_empty == (rsp.entry_count == 5'd0))
		else $error("empty flag disagrees with count");

	// underflow returns all ones on an empty queue
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_UNDERFLOW |->
			rsp.out_value == '1 && rsp.queue_empty && rsp.entry_count == 5'd0)
		else $error("bad underflow word");

	// full drop reports a full queue and zero value
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STATUS_FULL |->
			rsp.out_value == '0 && rsp.entry_count == 5'(CAPACITY) && !rsp.queue_empty)
		else $error("bad full word");

endmodule

bind sorted_priority_queue spq_port_checks u_spq_port_checks (.*);
